// ===== hw/rtl/ecg_pkg.sv =====
// Package for the easing curve generator: widths, curve and register codes,
// the divider stage type and the step function, and the exponential table.
// No dependencies.
package ecg_pkg;

  // Frame counter width and derived sizes
  localparam int unsigned FRAME_BITS      = 12;
  localparam int unsigned QBITS           = 12;  // quotient bits: i*3840/n < 2^12
  localparam int unsigned FRAC_BITS       = 8;   // 256 = full scale
  localparam int unsigned STEPS_PER_STAGE = 2;
  localparam int unsigned DIV_STAGES      = QBITS / STEPS_PER_STAGE;
  localparam int unsigned PROG_W          = 9;
  localparam int unsigned DATA_IN_W       = ((FRAME_BITS + 7) / 8) * 8;
  localparam int unsigned DATA_OUT_W      = ((PROG_W + 7) / 8) * 8;
  localparam int unsigned CFG_IDX_W       = 2;
  localparam int unsigned PROD_W          = 2 * PROG_W;

  // Curve codes
  localparam logic [1:0] MODE_LIN  = 2'd0;
  localparam logic [1:0] MODE_QUAD = 2'd1;
  localparam logic [1:0] MODE_EXPO = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CURVE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAMES = 2'd1;

  localparam logic [PROG_W-1:0] FULL_SCALE = 9'd256;

  // How the result is formed: from the curve, forced to 0 or forced to 256
  typedef enum logic [1:0] {
    KIND_NORMAL,
    KIND_ZERO,
    KIND_FULL
  } kind_e;

  // One item inside the divider: partial remainder, dividend/quotient shift word, curve and kind
  typedef struct packed {
    logic [FRAME_BITS-1:0] rem;
    logic [QBITS-1:0]      lq;
    logic [1:0]            mode;
    kind_e                 kind;
  } div_t;

  // One restoring division step: shift in a dividend bit, subtract if it fits
  function automatic div_t div_step(div_t s, logic [FRAME_BITS-1:0] n);
    div_t                r;
    logic [FRAME_BITS:0] trial;
    logic                qbit;
    r     = s;
    trial = {s.rem, s.lq[QBITS-1]};
    qbit  = 1'b0;
    if (trial >= {1'b0, n}) begin
      trial = trial - {1'b0, n};
      qbit  = 1'b1;
    end
    r.rem = trial[FRAME_BITS-1:0];
    r.lq  = {s.lq[QBITS-2:0], qbit};
    return r;
  endfunction

  // Exponential ease-out breakpoints
  function automatic logic [PROG_W-1:0] expo_lut(logic [3:0] idx);
    logic [PROG_W-1:0] v;
    case (idx)
      4'd0:    v = 9'd0;
      4'd1:    v = 9'd85;
      4'd2:    v = 9'd141;
      4'd3:    v = 9'd179;
      4'd4:    v = 9'd205;
      4'd5:    v = 9'd222;
      4'd6:    v = 9'd233;
      4'd7:    v = 9'd241;
      4'd8:    v = 9'd246;
      4'd9:    v = 9'd250;
      4'd10:   v = 9'd252;
      4'd11:   v = 9'd253;
      4'd12:   v = 9'd255;
      4'd13:   v = 9'd255;
      default: v = 9'd256;
    endcase
    return v;
  endfunction

endpackage

// ===== hw/rtl/easing_curve_generator.sv =====
// Easing curve generator: one item per cycle sustained while the result side
// is not stalled. The path is an entry register, the 12-bit restoring
// divider, two quotient bits per stage over six stages, then one multiply
// stage and the output register. Each stage stalls only when it is full and
// the one after it is stalled. Reset clears the valid bits and the registers
// to linear curve, zero frames. Depends on ecg_pkg.
module easing_curve_generator (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Configuration writes
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [ecg_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [ecg_pkg::FRAME_BITS-1:0]   cfg_data_i,
  // Input items
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  input  logic [ecg_pkg::DATA_IN_W-1:0]    s_axis_tdata_i,  // [11:0] frame_index
  // Result items
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  output logic [ecg_pkg::DATA_OUT_W-1:0]   m_axis_tdata_o   // [8:0] progress
);

  localparam int unsigned F  = ecg_pkg::FRAME_BITS;
  localparam int unsigned QB = ecg_pkg::QBITS;
  localparam int unsigned NS = ecg_pkg::DIV_STAGES;
  localparam int unsigned FB = ecg_pkg::FRAC_BITS;
  localparam int unsigned PW = ecg_pkg::PROG_W;

  // Configuration registers
  logic [1:0]   curve_mode_q;
  logic [F-1:0] frame_count_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      curve_mode_q  <= ecg_pkg::MODE_LIN;
      frame_count_q <= '0;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == ecg_pkg::CFG_CURVE) begin
        curve_mode_q <= cfg_data_i[1:0];
      end else if (cfg_index_i == ecg_pkg::CFG_FRAMES) begin
        frame_count_q <= cfg_data_i;
      end
    end
  end

  // Pipeline registers
  ecg_pkg::div_t     div_q [0:NS];
  logic              vld_q [0:NS];
  logic              rdy   [0:NS];
  logic              p_vld_q;
  logic [ecg_pkg::PROD_W-1:0] p_prod_q;
  logic [PW-1:0]     p_base_q;
  logic [1:0]        p_mode_q;
  ecg_pkg::kind_e    p_kind_q;
  logic              out_vld_q;
  logic [PW-1:0]     out_prog_q;
  logic              rdy_p;
  logic              rdy_out;

  // Backpressure: a stage takes an item when empty or when its successor moves
  always_comb begin
    rdy_out = !out_vld_q || m_axis_tready_i;
    rdy_p   = !p_vld_q || rdy_out;
    rdy[NS] = !vld_q[NS] || rdy_p;
    for (int k = NS - 1; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
  end

  assign s_axis_tready_o = rdy[0];

  // Entry: classify the index, form the dividend i*256 or i*3840
  logic [F-1:0]    in_idx;
  logic [F+QB-1:0] dvd_lin;
  logic [F+QB-1:0] dvd_x16;
  logic [F+QB-1:0] dvd;
  ecg_pkg::div_t   entry;

  always_comb begin
    in_idx  = s_axis_tdata_i[F-1:0];
    dvd_lin = {{(QB-FB){1'b0}}, in_idx, {FB{1'b0}}};
    dvd_x16 = {in_idx, {QB{1'b0}}};
    case (curve_mode_q)
      ecg_pkg::MODE_QUAD: entry.mode = ecg_pkg::MODE_QUAD;
      ecg_pkg::MODE_EXPO: entry.mode = ecg_pkg::MODE_EXPO;
      default:            entry.mode = ecg_pkg::MODE_LIN;
    endcase
    if (entry.mode == ecg_pkg::MODE_EXPO) begin
      dvd = dvd_x16 - dvd_lin;
    end else begin
      dvd = dvd_lin;
    end
    if (frame_count_q == '0 || in_idx >= frame_count_q) begin
      entry.kind = ecg_pkg::KIND_FULL;
    end else if (in_idx == '0) begin
      entry.kind = ecg_pkg::KIND_ZERO;
    end else begin
      entry.kind = ecg_pkg::KIND_NORMAL;
    end
    entry.rem = dvd[F+QB-1:QB];
    entry.lq  = dvd[QB-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (rdy[0]) begin
      vld_q[0] <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0] && s_axis_tvalid_i) begin
      div_q[0] <= entry;
    end
  end

  // Divider stages: the user must keep the frame count stable while items are in flight; the block does not enforce it
  for (genvar k = 1; k <= NS; k++) begin : g_div
    ecg_pkg::div_t nxt;

    always_comb begin
      nxt = div_q[k-1];
      for (int s = 0; s < ecg_pkg::STEPS_PER_STAGE; s++) begin
        nxt = ecg_pkg::div_step(nxt, frame_count_q);
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (rdy[k]) begin
        vld_q[k] <= vld_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[k] && vld_q[k-1]) begin
        div_q[k] <= nxt;
      end
    end
  end

  // Multiply stage: square of the remaining distance, segment interpolation, or the linear fraction as is
  logic [QB-1:0] quo;
  logic [FB-1:0] frac;
  logic [3:0]    seg;
  logic [PW-1:0] lo;
  logic [PW-1:0] hi;
  logic [PW-1:0] mul_a;
  logic [PW-1:0] mul_b;
  logic [PW-1:0] base;

  always_comb begin
    quo  = div_q[NS].lq;
    frac = quo[FB-1:0];
    seg  = quo[QB-1:FB];
    lo   = ecg_pkg::expo_lut(seg);
    hi   = ecg_pkg::expo_lut(seg + 4'd1);
    case (div_q[NS].mode)
      ecg_pkg::MODE_QUAD: begin
        mul_a = ecg_pkg::FULL_SCALE - {1'b0, frac};
        mul_b = ecg_pkg::FULL_SCALE - {1'b0, frac};
        base  = ecg_pkg::FULL_SCALE;
      end
      ecg_pkg::MODE_EXPO: begin
        mul_a = hi - lo;
        mul_b = {1'b0, frac};
        base  = lo;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
        base  = {1'b0, frac};
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_vld_q <= 1'b0;
    end else if (rdy_p) begin
      p_vld_q <= vld_q[NS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_p && vld_q[NS]) begin
      p_prod_q <= ecg_pkg::PROD_W'(mul_a) * ecg_pkg::PROD_W'(mul_b);
      p_base_q <= base;
      p_mode_q <= div_q[NS].mode;
      p_kind_q <= div_q[NS].kind;
    end
  end

  // Output stage: scale the product, combine with the base, apply end cases
  logic [PW:0] scaled;
  logic [PW:0] res;

  always_comb begin
    scaled = p_prod_q[ecg_pkg::PROD_W-1:FB];
    case (p_mode_q)
      ecg_pkg::MODE_QUAD: res = {1'b0, ecg_pkg::FULL_SCALE} - scaled;
      ecg_pkg::MODE_EXPO: res = {1'b0, p_base_q} + scaled;
      default:            res = {1'b0, p_base_q};
    endcase
    case (p_kind_q)
      ecg_pkg::KIND_FULL: res = {1'b0, ecg_pkg::FULL_SCALE};
      ecg_pkg::KIND_ZERO: res = '0;
      default:            res = res;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (rdy_out) begin
      out_vld_q <= p_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_out && p_vld_q) begin
      out_prog_q <= res[PW-1:0];
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {{(ecg_pkg::DATA_OUT_W-PW){1'b0}}, out_prog_q};

endmodule

// ===== hw/rtl/ecg_checker.sv =====
// Port-level checks for the easing curve generator, and the bind that
// attaches them to the top level. Depends on ecg_pkg and easing_curve_generator.
module ecg_checker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tready_o,
  input  logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  input  logic [ecg_pkg::DATA_OUT_W-1:0]   m_axis_tdata_o
);

  // Hold a stalled result item unchanged
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result item changed while stalled");

  // Progress never exceeds full scale
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[ecg_pkg::PROG_W-1:0] <= ecg_pkg::FULL_SCALE)
    else $error("progress above full scale");

  // Drive the pad bits of tdata low
  a_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |->
      (m_axis_tdata_o >> ecg_pkg::PROG_W) == '0)
    else $error("tdata pad bits set");

  // Refuse input only when a finished result is held back
  a_no_idle_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> m_axis_tvalid_o && !m_axis_tready_i)
    else $error("input refused without output backpressure");

endmodule

bind easing_curve_generator ecg_checker u_ecg_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);
